// File: src/div128_pkg.sv
// Shared constants and types for the 128-by-64 unsigned divider.
package div128_pkg;

  localparam int FIELD_BITS = 64;
  localparam int ERR_BITS   = 2;
  localparam int WORD_BITS_DEFAULT = 64;

  localparam logic [ERR_BITS-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_OVERFLOW = 2'd2;

  // Control broadcast to every cell of the remainder row.
  typedef struct packed {
    logic load;  // capture new operand bits
    logic step;  // advance one restoring step
    logic sub;   // keep the difference this step (quotient bit is one)
  } cell_ctrl_t;

endpackage

// File: src/divide_128_by_64.sv
// Top level of the unsigned 128-by-64 divider built from a row of bit-slice cells.
//
//   channel  direction  tdata fields (lowest bit up)                      handshake
//   s_axis   in         dividend_high[63:0], dividend_low[127:64],        tvalid/tready
//                       divisor[191:128]
//   m_axis   out        quotient[63:0], error_code[65:64], zero pad        tvalid/tready
//
// An item with a valid divisor steps through the cell row, one quotient bit per cycle (set by
// the borrow chain through the row), and the quotient then moves to the output register; the
// next item can be accepted while the quotient moves.
// An item flagged as an error skips the row's steps and goes straight to the done state.
// Reset (rst, synchronous) clears the sequencer and the output valid flag.
// A stalled output holds the finished quotient in the row; no new item enters until it moves.
module divide_128_by_64 #(
  parameter int WORD_BITS = div128_pkg::WORD_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dividend_high [63:0], dividend_low [127:64], divisor [191:128]
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quotient [63:0], error_code [65:64], zero [71:66]
  output logic [71:0]  m_axis_tdata
);
  import div128_pkg::*;

  localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state;
  logic [CNT_BITS-1:0]   cnt;
  logic [ERR_BITS-1:0]   err;
  logic [FIELD_BITS-1:0] out_q;
  logic [ERR_BITS-1:0]   out_err;
  logic                  out_valid;

  logic [WORD_BITS-1:0]  in_hi;
  logic [WORD_BITS-1:0]  in_lo;
  logic [WORD_BITS-1:0]  in_d;
  logic [ERR_BITS-1:0]   in_err;
  logic                  in_acc;
  logic                  out_free;

  logic [WORD_BITS-1:0]  r_vec;
  logic [WORD_BITS-1:0]  lo_vec;
  logic [WORD_BITS-1:0]  b_vec;
  cell_ctrl_t            ctrl;
  logic [FIELD_BITS-1:0] q_word;

  // Bits above WORD_BITS are ignored.
  assign in_hi = s_axis_tdata[WORD_BITS-1:0];
  assign in_lo = s_axis_tdata[FIELD_BITS +: WORD_BITS];
  assign in_d  = s_axis_tdata[2*FIELD_BITS +: WORD_BITS];

  // Zero divisor wins over overflow.
  always_comb begin
    if (in_d == '0) begin
      in_err = ERR_DIV_ZERO;
    end else if (in_hi >= in_d) begin
      in_err = ERR_OVERFLOW;
    end else begin
      in_err = ERR_OK;
    end
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) || ((state == ST_DONE) && out_free);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Subtract when the bit shifted out of the remainder is set or no borrow left the row.
  assign ctrl.load = in_acc;
  assign ctrl.step = (state == ST_RUN);
  assign ctrl.sub  = r_vec[WORD_BITS-1] | ~b_vec[WORD_BITS-1];

  // Remainder row: cell 0 takes the next dividend bit from the top of the low word,
  // and the quotient bit enters the low word from below as it drains.
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    logic r_in;
    logic lo_in;
    logic b_in;
    if (i == 0) begin : g_first
      assign r_in  = lo_vec[WORD_BITS-1];
      assign lo_in = ctrl.sub;
      assign b_in  = 1'b0;
    end else begin : g_rest
      assign r_in  = r_vec[i-1];
      assign lo_in = lo_vec[i-1];
      assign b_in  = b_vec[i-1];
    end
    div128_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_r    (in_hi[i]),
      .load_lo   (in_lo[i]),
      .load_d    (in_d[i]),
      .r_in      (r_in),
      .lo_in     (lo_in),
      .borrow_in (b_in),
      .r_out     (r_vec[i]),
      .lo_out    (lo_vec[i]),
      .borrow_out(b_vec[i])
    );
  end

  // Quotient word: the row's result, or all ones of WORD_BITS bits on error.
  always_comb begin
    q_word = '0;
    if (err == ERR_OK) begin
      q_word[WORD_BITS-1:0] = lo_vec;
    end else begin
      q_word[WORD_BITS-1:0] = '1;
    end
  end

  // Sequencer: accept, run WORD_BITS steps (an error item skips them), hand off to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      err   <= ERR_OK;
    end else if (in_acc) begin
      state <= (in_err == ERR_OK) ? ST_RUN : ST_DONE;
      cnt   <= CNT_BITS'(WORD_BITS - 1);
      err   <= in_err;
    end else begin
      case (state)
        ST_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load when the result is done and the slot is free, drop on take.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_q   <= q_word;
      out_err <= err;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_err, out_q};

`ifndef SYNTH
  a_err_ones: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_err != ERR_OK)) |-> (out_q[WORD_BITS-1:0] == '1))
    else $error("error item without all-ones quotient");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_err == ERR_OK) || (out_err == ERR_DIV_ZERO) ||
                   (out_err == ERR_OVERFLOW)))
    else $error("unknown error code on output");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_err == ERR_OK)) |=>
      ((state == ST_RUN) && (cnt == CNT_BITS'(WORD_BITS - 1))))
    else $error("valid item did not start a full run");

  a_no_accept_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !s_axis_tready)
    else $error("input accepted while the row is busy");
`endif

endmodule

// File: src/div128_cell.sv
// One bit slice of the restoring divider: remainder, dividend/quotient and divisor bits.
module div128_cell (
  input  logic                   clk,
  input  div128_pkg::cell_ctrl_t ctrl,
  input  logic                   load_r,
  input  logic                   load_lo,
  input  logic                   load_d,
  input  logic                   r_in,
  input  logic                   lo_in,
  input  logic                   borrow_in,
  output logic                   r_out,
  output logic                   lo_out,
  output logic                   borrow_out
);
  import div128_pkg::*;

  logic r;
  logic lo;
  logic d;
  logic diff;

  // r_in is the neighbor's remainder bit, i.e. this slice of the shifted remainder.
  assign diff       = r_in ^ d ^ borrow_in;
  assign borrow_out = (~r_in & (d | borrow_in)) | (d & borrow_in);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r  <= load_r;
      lo <= load_lo;
      d  <= load_d;
    end else if (ctrl.step) begin
      r  <= ctrl.sub ? diff : r_in;
      lo <= lo_in;
    end
  end

  assign r_out  = r;
  assign lo_out = lo;

endmodule
